// File: rtl/rmro_pkg.sv
package rmro_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int MID_W     = 30;
  localparam int F_W       = MID_W + 1;
  localparam int ACC_W     = 64;
  localparam int ZN_W      = MID_W + F_W - FRAC_BITS - 1;

  // product widths
  localparam int PXY_W = 2 * IN_W;
  localparam int PE_W  = IN_W + MID_W;
  localparam int PSQ_W = 2 * MID_W;
  localparam int PF_W  = MID_W + F_W;
  localparam int PO_W  = IN_W + ZN_W;

  // stage counts per unit
  localparam int ORT_LAT  = 4;
  localparam int PRD_LAT  = 4;
  localparam int SCL_LAT  = 3;
  localparam int ORI_LAT  = 2;
  localparam int Z_DLY    = ORT_LAT + PRD_LAT + SCL_LAT;
  localparam int PIPE_LAT = Z_DLY + ORI_LAT;

  // cross product index rotation
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  typedef logic signed [IN_W-1:0]  in_t;
  typedef logic signed [MID_W-1:0] mid_t;
  typedef logic signed [F_W-1:0]   fac_t;
  typedef logic signed [ZN_W-1:0]  zn_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef in_t      in_vec_t  [3];
  typedef in_vec_t  in_mat_t  [3];
  typedef mid_t     mid_vec_t [3];
  typedef mid_vec_t mid_mat_t [3];
  typedef zn_t      zn_vec_t  [3];
  typedef zn_vec_t  zn_mat_t  [3];

  localparam acc_t MID_MAX = (acc_t'(1) <<< (MID_W - 1)) - acc_t'(1);
  localparam acc_t MID_MIN = -(acc_t'(1) <<< (MID_W - 1));
  localparam acc_t OUT_MAX = (acc_t'(1) <<< (IN_W - 1)) - acc_t'(1);
  localparam acc_t OUT_MIN = -(acc_t'(1) <<< (IN_W - 1));
  localparam fac_t F_THREE = fac_t'(3) <<< FRAC_BITS;

  // divide by 2^s, ties go up
  function automatic acc_t rnd_shift(input acc_t v, input int unsigned s);
    acc_t half;
    half = acc_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic acc_t rnd_frac(input acc_t v);
    return rnd_shift(v, FRAC_BITS);
  endfunction

  function automatic acc_t rnd_half(input acc_t v);
    return rnd_shift(v, FRAC_BITS + 1);
  endfunction

  function automatic mid_t sat_mid(input acc_t v);
    acc_t r;
    r = v;
    if (v > MID_MAX) begin
      r = MID_MAX;
    end else if (v < MID_MIN) begin
      r = MID_MIN;
    end
    return mid_t'(r);
  endfunction

  function automatic in_t sat_out(input acc_t v);
    acc_t r;
    r = v;
    if (v > OUT_MAX) begin
      r = OUT_MAX;
    end else if (v < OUT_MIN) begin
      r = OUT_MIN;
    end
    return in_t'(r);
  endfunction

endpackage

// File: rtl/rmro_ortho.sv
module rmro_ortho (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rmro_pkg::in_vec_t  x_i,
  input  rmro_pkg::in_vec_t  y_i,
  output logic               valid_o,
  output rmro_pkg::mid_vec_t xo_o,
  output rmro_pkg::mid_vec_t yo_o
);
  import rmro_pkg::*;

  logic [ORT_LAT-1:0]      vld_d, vld_q;
  in_vec_t                 x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic signed [PXY_W-1:0] pxy_d [3];
  logic signed [PXY_W-1:0] pxy_q [3];
  mid_t                    e_d, e_q;
  logic signed [PE_W-1:0]  pye_d [3];
  logic signed [PE_W-1:0]  pye_q [3];
  logic signed [PE_W-1:0]  pxe_d [3];
  logic signed [PE_W-1:0]  pxe_q [3];
  mid_vec_t                xo_d, xo_q, yo_d, yo_q;

  // dot product, error products, half-error removal
  always_comb begin
    vld_d = {vld_q[ORT_LAT-2:0], valid_i};
    e_d   = sat_mid(rnd_frac(acc_t'(pxy_q[0]) + acc_t'(pxy_q[1]) + acc_t'(pxy_q[2])));
    for (int i = 0; i < 3; i++) begin
      pxy_d[i] = x_i[i] * y_i[i];
      pye_d[i] = y2_q[i] * e_q;
      pxe_d[i] = x2_q[i] * e_q;
      xo_d[i]  = sat_mid(acc_t'(x3_q[i]) - rnd_half(acc_t'(pye_q[i])));
      yo_d[i]  = sat_mid(acc_t'(y3_q[i]) - rnd_half(acc_t'(pxe_q[i])));
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    x1_q  <= x_i;
    y1_q  <= y_i;
    pxy_q <= pxy_d;
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    e_q   <= e_d;
    x3_q  <= x2_q;
    y3_q  <= y2_q;
    pye_q <= pye_d;
    pxe_q <= pxe_d;
    xo_q  <= xo_d;
    yo_q  <= yo_d;
  end

  assign valid_o = vld_q[ORT_LAT-1];
  assign xo_o    = xo_q;
  assign yo_o    = yo_q;

endmodule

// File: rtl/rmro_prod.sv
module rmro_prod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rmro_pkg::mid_vec_t xo_i,
  input  rmro_pkg::mid_vec_t yo_i,
  output logic               valid_o,
  output rmro_pkg::mid_mat_t v_o,
  output rmro_pkg::mid_vec_t n_o
);
  import rmro_pkg::*;

  logic [PRD_LAT-1:0]      vld_d, vld_q;
  logic signed [PSQ_W-1:0] cpa_d [3];
  logic signed [PSQ_W-1:0] cpa_q [3];
  logic signed [PSQ_W-1:0] cpb_d [3];
  logic signed [PSQ_W-1:0] cpb_q [3];
  logic signed [PSQ_W-1:0] sqx_d [3];
  logic signed [PSQ_W-1:0] sqx_q [3];
  logic signed [PSQ_W-1:0] sqy_d [3];
  logic signed [PSQ_W-1:0] sqy_q [3];
  logic signed [PSQ_W-1:0] sqz_d [3];
  logic signed [PSQ_W-1:0] sqz_q [3];
  mid_vec_t                x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  mid_vec_t                zo_d, z2_q, z3_q, z4_q;
  mid_t                    nx_d, ny_d, nz_d;
  mid_t                    nx2_q, ny2_q, nx3_q, ny3_q, nx4_q, ny4_q, nz4_q;

  // cross product, squared norms of the corrected rows
  always_comb begin
    vld_d = {vld_q[PRD_LAT-2:0], valid_i};
    for (int i = 0; i < 3; i++) begin
      cpa_d[i] = xo_i[NXT[i]] * yo_i[PRV[i]];
      cpb_d[i] = xo_i[PRV[i]] * yo_i[NXT[i]];
      sqx_d[i] = xo_i[i] * xo_i[i];
      sqy_d[i] = yo_i[i] * yo_i[i];
      zo_d[i]  = sat_mid(rnd_frac(acc_t'(cpa_q[i]) - acc_t'(cpb_q[i])));
      sqz_d[i] = z2_q[i] * z2_q[i];
    end
    nx_d = sat_mid(rnd_frac(acc_t'(sqx_q[0]) + acc_t'(sqx_q[1]) + acc_t'(sqx_q[2])));
    ny_d = sat_mid(rnd_frac(acc_t'(sqy_q[0]) + acc_t'(sqy_q[1]) + acc_t'(sqy_q[2])));
    nz_d = sat_mid(rnd_frac(acc_t'(sqz_q[0]) + acc_t'(sqz_q[1]) + acc_t'(sqz_q[2])));
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    cpa_q <= cpa_d;
    cpb_q <= cpb_d;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
    x1_q  <= xo_i;
    y1_q  <= yo_i;
    z2_q  <= zo_d;
    nx2_q <= nx_d;
    ny2_q <= ny_d;
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    sqz_q <= sqz_d;
    x3_q  <= x2_q;
    y3_q  <= y2_q;
    z3_q  <= z2_q;
    nx3_q <= nx2_q;
    ny3_q <= ny2_q;
    nz4_q <= nz_d;
    x4_q  <= x3_q;
    y4_q  <= y3_q;
    z4_q  <= z3_q;
    nx4_q <= nx3_q;
    ny4_q <= ny3_q;
  end

  assign valid_o = vld_q[PRD_LAT-1];
  assign v_o[0]  = x4_q;
  assign v_o[1]  = y4_q;
  assign v_o[2]  = z4_q;
  assign n_o[0]  = nx4_q;
  assign n_o[1]  = ny4_q;
  assign n_o[2]  = nz4_q;

endmodule

// File: rtl/rmro_scale.sv
module rmro_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rmro_pkg::mid_mat_t v_i,
  input  rmro_pkg::mid_vec_t n_i,
  output logic               valid_o,
  output rmro_pkg::zn_mat_t  vn_o
);
  import rmro_pkg::*;

  logic [SCL_LAT-1:0]     vld_d, vld_q;
  fac_t                   f_d [3];
  fac_t                   f_q [3];
  mid_mat_t               v1_q;
  logic signed [PF_W-1:0] p_d [3][3];
  logic signed [PF_W-1:0] p_q [3][3];
  zn_mat_t                vn_d, vn_q;

  // one-step normalization: v * (3 - |v|^2) / 2
  always_comb begin
    vld_d = {vld_q[SCL_LAT-2:0], valid_i};
    for (int r = 0; r < 3; r++) begin
      f_d[r] = F_THREE - fac_t'(n_i[r]);
      for (int c = 0; c < 3; c++) begin
        p_d[r][c]  = v1_q[r][c] * f_q[r];
        vn_d[r][c] = zn_t'(rnd_half(acc_t'(p_q[r][c])));
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    f_q  <= f_d;
    v1_q <= v_i;
    p_q  <= p_d;
    vn_q <= vn_d;
  end

  assign valid_o = vld_q[SCL_LAT-1];
  assign vn_o    = vn_q;

endmodule

// File: rtl/rmro_orient.sv
module rmro_orient (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rmro_pkg::in_vec_t z0_i,
  input  rmro_pkg::zn_mat_t vn_i,
  output logic              valid_o,
  output rmro_pkg::in_mat_t res_o,
  output logic              mirrored_o
);
  import rmro_pkg::*;

  logic [ORI_LAT-1:0]     vld_d, vld_q;
  logic signed [PO_W-1:0] po_d [3];
  logic signed [PO_W-1:0] po_q [3];
  zn_mat_t                vn1_q;
  acc_t                   orient;
  logic                   mir_d, mir_q;
  in_mat_t                res_d, res_q;

  // orientation against the reference row, optional negation, saturation
  always_comb begin
    vld_d  = {vld_q[ORI_LAT-2:0], valid_i};
    orient = acc_t'(po_q[0]) + acc_t'(po_q[1]) + acc_t'(po_q[2]);
    mir_d  = orient[ACC_W-1];
    for (int i = 0; i < 3; i++) begin
      po_d[i]     = z0_i[i] * vn_i[2][i];
      res_d[0][i] = sat_out(acc_t'(vn1_q[0][i]));
      res_d[1][i] = sat_out(acc_t'(vn1_q[1][i]));
      res_d[2][i] = mir_d ? sat_out(-acc_t'(vn1_q[2][i])) : sat_out(acc_t'(vn1_q[2][i]));
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    po_q  <= po_d;
    vn1_q <= vn_i;
    res_q <= res_d;
    mir_q <= mir_d;
  end

  assign valid_o    = vld_q[ORI_LAT-1];
  assign res_o      = res_q;
  assign mirrored_o = mir_q;

endmodule

// File: rtl/rotation_matrix_reorthogonalize_top.sv
// Re-orthogonalizes a 3x3 rotation estimate given as rows x, y, z in signed Q2.16. Half of
// the x.y error is taken out of each of x and y, z is rebuilt as x cross y, every row gets a
// one-step normalization by (3 - |v|^2)/2, and z is negated (mirrored_o high) when it points
// against the input z. A word is taken on every clock edge where start is high; busy stays
// low, so one word per cycle streams in without gaps. Each result shows on the output ports
// for one cycle with valid_o high, in input order, at the end of the 13-stage pipeline:
// dot product, error scaling, cross products, norms, scale factor, normalization and the
// orientation sum each hold one or two multiplier stages. Results cannot be held off, so
// nothing in the pipe ever stalls.
module rotation_matrix_reorthogonalize_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rmro_pkg::in_t in_x0_i,
  input  rmro_pkg::in_t in_x1_i,
  input  rmro_pkg::in_t in_x2_i,
  input  rmro_pkg::in_t in_y0_i,
  input  rmro_pkg::in_t in_y1_i,
  input  rmro_pkg::in_t in_y2_i,
  input  rmro_pkg::in_t in_z0_i,
  input  rmro_pkg::in_t in_z1_i,
  input  rmro_pkg::in_t in_z2_i,
  output logic          valid_o,
  output rmro_pkg::in_t out_x0_o,
  output rmro_pkg::in_t out_x1_o,
  output rmro_pkg::in_t out_x2_o,
  output rmro_pkg::in_t out_y0_o,
  output rmro_pkg::in_t out_y1_o,
  output rmro_pkg::in_t out_y2_o,
  output rmro_pkg::in_t out_z0_o,
  output rmro_pkg::in_t out_z1_o,
  output rmro_pkg::in_t out_z2_o,
  output logic          mirrored_o
);
  import rmro_pkg::*;

  logic     accept;
  in_vec_t  x_in, y_in, z_in;
  in_vec_t  zd_q [Z_DLY];
  logic     ort_vld, prd_vld, scl_vld;
  mid_vec_t xo, yo;
  mid_mat_t rows;
  mid_vec_t norms;
  zn_mat_t  rows_n;
  in_mat_t  res;

  // pipeline never holds off a word
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign x_in[0] = in_x0_i;
  assign x_in[1] = in_x1_i;
  assign x_in[2] = in_x2_i;
  assign y_in[0] = in_y0_i;
  assign y_in[1] = in_y1_i;
  assign y_in[2] = in_y2_i;
  assign z_in[0] = in_z0_i;
  assign z_in[1] = in_z1_i;
  assign z_in[2] = in_z2_i;

  // reference row delay line, aligned with the normalized rows
  always_ff @(posedge clk_i) begin
    zd_q[0] <= z_in;
    for (int k = 1; k < Z_DLY; k++) begin
      zd_q[k] <= zd_q[k-1];
    end
  end

  rmro_ortho u_ortho (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (x_in),
    .y_i     (y_in),
    .valid_o (ort_vld),
    .xo_o    (xo),
    .yo_o    (yo)
  );

  rmro_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ort_vld),
    .xo_i    (xo),
    .yo_i    (yo),
    .valid_o (prd_vld),
    .v_o     (rows),
    .n_o     (norms)
  );

  rmro_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prd_vld),
    .v_i     (rows),
    .n_i     (norms),
    .valid_o (scl_vld),
    .vn_o    (rows_n)
  );

  rmro_orient u_orient (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (scl_vld),
    .z0_i       (zd_q[Z_DLY-1]),
    .vn_i       (rows_n),
    .valid_o    (valid_o),
    .res_o      (res),
    .mirrored_o (mirrored_o)
  );

  assign out_x0_o = res[0][0];
  assign out_x1_o = res[0][1];
  assign out_x2_o = res[0][2];
  assign out_y0_o = res[1][0];
  assign out_y1_o = res[1][1];
  assign out_y2_o = res[1][2];
  assign out_z0_o = res[2][0];
  assign out_z1_o = res[2][1];
  assign out_z2_o = res[2][2];

endmodule

// File: rtl/rmro_checker.sv
module rmro_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input rmro_pkg::in_t in_x0_i,
  input rmro_pkg::in_t in_x1_i,
  input rmro_pkg::in_t in_x2_i,
  input rmro_pkg::in_t in_z0_i,
  input rmro_pkg::in_t in_z1_i,
  input rmro_pkg::in_t in_z2_i,
  input logic          valid_o,
  input rmro_pkg::in_t out_x0_o,
  input rmro_pkg::in_t out_x1_o,
  input rmro_pkg::in_t out_x2_o,
  input rmro_pkg::in_t out_z0_o,
  input rmro_pkg::in_t out_z1_o,
  input rmro_pkg::in_t out_z2_o,
  input logic          mirrored_o
);
  import rmro_pkg::*;

  logic took, x_zero, z_zero;

  assign took   = start & ~busy;
  assign x_zero = (in_x0_i == '0) && (in_x1_i == '0) && (in_x2_i == '0);
  assign z_zero = (in_z0_i == '0) && (in_z1_i == '0) && (in_z2_i == '0);

  // every word taken comes out after the fixed latency
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    took |-> ##PIPE_LAT valid_o)
    else $error("result missing after pipeline latency");

  // no result without a word taken at the matching edge
  a_lat_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(took, PIPE_LAT))
    else $error("result without matching input word");

  // a zero reference row can never call for a flip
  a_no_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(z_zero, PIPE_LAT) |-> !mirrored_o)
    else $error("mirrored with zero reference row");

  // a zero first row yields zero first and third rows
  a_zero_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(x_zero, PIPE_LAT) |->
      (out_x0_o == '0) && (out_x1_o == '0) && (out_x2_o == '0) &&
      (out_z0_o == '0) && (out_z1_o == '0) && (out_z2_o == '0) && !mirrored_o)
    else $error("zero first row gave nonzero result");

endmodule

bind rotation_matrix_reorthogonalize_top rmro_checker u_rmro_checker (.*);

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmro_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int IN_MAX      = (1 << (IN_W - 1)) - 1;
  localparam int IN_MIN      = -(1 << (IN_W - 1));

  // nine components in row order x0..x2, y0..y2, z0..z2
  typedef logic [8:0][IN_W-1:0] matrix_t;

  typedef struct packed {
    matrix_t comp;
    logic    mirrored;
  } reortho_t;

  // predicts the corrected rows and checks them against the block
  class reortho_scoreboard;
    reortho_t    pending_q[$];
    int unsigned errors = 0;

    // divide by 2^s with ties going up
    static function longint round_shift(longint v, int unsigned s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      if (v < lo) begin
        return lo;
      end
      if (v > hi) begin
        return hi;
      end
      return v;
    endfunction

    static function longint mid_sat(longint v);
      return clip(v, MID_MIN, MID_MAX);
    endfunction

    // 3 - |v|^2 at FRAC_BITS, the halving is folded into the final rounding
    static function longint scale_factor(longint a, longint b, longint c);
      longint n;
      n = mid_sat(round_shift(a * a + b * b + c * c, FRAC_BITS));
      return (longint'(3) <<< FRAC_BITS) - n;
    endfunction

    function reortho_t reorthogonalize(matrix_t m);
      longint   x [3];
      longint   y [3];
      longint   zr [3];
      longint   xo [3];
      longint   yo [3];
      longint   zo [3];
      longint   xn [3];
      longint   yn [3];
      longint   zn [3];
      longint   e;
      longint   fx;
      longint   fy;
      longint   fz;
      longint   orient;
      reortho_t r;
      for (int i = 0; i < 3; i++) begin
        x[i]  = longint'($signed(m[i]));
        y[i]  = longint'($signed(m[3 + i]));
        zr[i] = longint'($signed(m[6 + i]));
      end
      // share the x.y error between the first two rows
      e = mid_sat(round_shift(x[0] * y[0] + x[1] * y[1] + x[2] * y[2], FRAC_BITS));
      for (int i = 0; i < 3; i++) begin
        xo[i] = mid_sat(x[i] - round_shift(y[i] * e, FRAC_BITS + 1));
        yo[i] = mid_sat(y[i] - round_shift(x[i] * e, FRAC_BITS + 1));
      end
      // third row is the cross product of the corrected rows
      for (int i = 0; i < 3; i++) begin
        zo[i] = mid_sat(round_shift(xo[(i + 1) % 3] * yo[(i + 2) % 3]
                                    - xo[(i + 2) % 3] * yo[(i + 1) % 3], FRAC_BITS));
      end
      // one-step normalization of every row
      fx = scale_factor(xo[0], xo[1], xo[2]);
      fy = scale_factor(yo[0], yo[1], yo[2]);
      fz = scale_factor(zo[0], zo[1], zo[2]);
      for (int i = 0; i < 3; i++) begin
        xn[i] = round_shift(xo[i] * fx, FRAC_BITS + 1);
        yn[i] = round_shift(yo[i] * fy, FRAC_BITS + 1);
        zn[i] = round_shift(zo[i] * fz, FRAC_BITS + 1);
      end
      // flip z only when it strictly opposes the reference row
      orient = zr[0] * zn[0] + zr[1] * zn[1] + zr[2] * zn[2];
      r.mirrored = (orient < 0);
      for (int i = 0; i < 3; i++) begin
        if (r.mirrored) begin
          zn[i] = -zn[i];
        end
        r.comp[i]     = in_t'(clip(xn[i], OUT_MIN, OUT_MAX));
        r.comp[3 + i] = in_t'(clip(yn[i], OUT_MIN, OUT_MAX));
        r.comp[6 + i] = in_t'(clip(zn[i], OUT_MIN, OUT_MAX));
      end
      return r;
    endfunction

    function void note_matrix(matrix_t m);
      pending_q.push_back(reorthogonalize(m));
    endfunction

    function void check_result(reortho_t got);
      reortho_t exp_r;
      string    axes = "xyz";
      if (pending_q.size() == 0) begin
        $error("result word with no matrix pending");
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (got.comp[i] !== exp_r.comp[i]) begin
          $error("out_%s%0d expected %0d actual %0d", axes.substr(i / 3, i / 3), i % 3,
                 $signed(exp_r.comp[i]), $signed(got.comp[i]));
          errors++;
        end
      end
      if (got.mirrored !== exp_r.mirrored) begin
        $error("mirrored expected %0b actual %0b", exp_r.mirrored, got.mirrored);
        errors++;
      end
    endfunction

    function void report_leftovers();
      if (pending_q.size() != 0) begin
        $error("%0d result words never arrived", pending_q.size());
        errors += pending_q.size();
      end
    endfunction
  endclass

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start   = 1'b0;
  logic busy;
  in_t  in_x0_i = '0;
  in_t  in_x1_i = '0;
  in_t  in_x2_i = '0;
  in_t  in_y0_i = '0;
  in_t  in_y1_i = '0;
  in_t  in_y2_i = '0;
  in_t  in_z0_i = '0;
  in_t  in_z1_i = '0;
  in_t  in_z2_i = '0;
  logic valid_o;
  in_t  out_x0_o;
  in_t  out_x1_o;
  in_t  out_x2_o;
  in_t  out_y0_o;
  in_t  out_y1_o;
  in_t  out_y2_o;
  in_t  out_z0_o;
  in_t  out_z1_o;
  in_t  out_z2_o;
  logic mirrored_o;

  reortho_scoreboard sb = new();
  int                quiet_cycles = 0;

  rotation_matrix_reorthogonalize_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_x0_i    (in_x0_i),
    .in_x1_i    (in_x1_i),
    .in_x2_i    (in_x2_i),
    .in_y0_i    (in_y0_i),
    .in_y1_i    (in_y1_i),
    .in_y2_i    (in_y2_i),
    .in_z0_i    (in_z0_i),
    .in_z1_i    (in_z1_i),
    .in_z2_i    (in_z2_i),
    .valid_o    (valid_o),
    .out_x0_o   (out_x0_o),
    .out_x1_o   (out_x1_o),
    .out_x2_o   (out_x2_o),
    .out_y0_o   (out_y0_o),
    .out_y1_o   (out_y1_o),
    .out_y2_o   (out_y2_o),
    .out_z0_o   (out_z0_o),
    .out_z1_o   (out_z1_o),
    .out_z2_o   (out_z2_o),
    .mirrored_o (mirrored_o)
  );

  always #4 clk_i = ~clk_i;

  // watch both handshakes, values seen here are the ones from before the edge
  always @(posedge clk_i) begin : monitor
    reortho_t got;
    logic     moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_matrix({in_z2_i, in_z1_i, in_z0_i, in_y2_i, in_y1_i, in_y0_i,
                        in_x2_i, in_x1_i, in_x0_i});
        moved = 1'b1;
      end
      if (valid_o) begin
        got.comp     = {out_z2_o, out_z1_o, out_z0_o, out_y2_o, out_y1_o, out_y0_o,
                        out_x2_o, out_x1_o, out_x0_o};
        got.mirrored = mirrored_o;
        sb.check_result(got);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic in_t fit(int v);
    if (v > IN_MAX) begin
      return in_t'(IN_MAX);
    end
    if (v < IN_MIN) begin
      return in_t'(IN_MIN);
    end
    return in_t'(v);
  endfunction

  function automatic matrix_t rows(int x0, int x1, int x2, int y0, int y1, int y2,
                                   int z0, int z1, int z2);
    matrix_t m;
    m = {fit(z2), fit(z1), fit(z0), fit(y2), fit(y1), fit(y0), fit(x2), fit(x1), fit(x0)};
    return m;
  endfunction

  // a field value biased toward the range ends
  function automatic int edge_value();
    case ($urandom_range(0, 7))
      0: return IN_MIN;
      1: return IN_MAX;
      2: return 0;
      3: return 1;
      4: return -1;
      5: return ONE;
      6: return -ONE;
      default: return int'($urandom_range(0, 2 * IN_MAX + 1)) + IN_MIN;
    endcase
  endfunction

  // mostly noisy rotations, some raw noise and some range ends
  function automatic matrix_t random_rows();
    real     ca, sa, cb, sb_, cc, sc, gain;
    real     r [9];
    int      c [9];
    int      kind;
    int      amp;
    int      zref;
    matrix_t m;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      ca = $cos($urandom_range(0, 62831) / 10000.0);
      sa = $sin($acos(ca)) * (($urandom_range(0, 1) == 1) ? 1.0 : -1.0);
      cb = $cos($urandom_range(0, 62831) / 10000.0);
      sb_ = $sin($acos(cb)) * (($urandom_range(0, 1) == 1) ? 1.0 : -1.0);
      cc = $cos($urandom_range(0, 62831) / 10000.0);
      sc = $sin($acos(cc)) * (($urandom_range(0, 1) == 1) ? 1.0 : -1.0);
      r[0] = ca * cb;
      r[1] = ca * sb_ * sc - sa * cc;
      r[2] = ca * sb_ * cc + sa * sc;
      r[3] = sa * cb;
      r[4] = sa * sb_ * sc + ca * cc;
      r[5] = sa * sb_ * cc - ca * sc;
      r[6] = -sb_;
      r[7] = cb * sc;
      r[8] = cb * cc;
      gain = ($urandom_range(0, 9) == 0) ? 1.0 + $urandom_range(0, 500) / 1000.0 : 1.0;
      amp  = 1 << $urandom_range(0, 14);
      zref = $urandom_range(0, 99);
      for (int i = 0; i < 9; i++) begin
        c[i] = int'(r[i] * gain * ONE) + int'($urandom_range(0, 2 * amp)) - amp;
        if (i >= 6 && zref >= 60 && zref < 85) begin
          c[i] = -c[i];
        end else if (i >= 6 && zref >= 85) begin
          c[i] = edge_value();
        end
      end
    end else if (kind < 85) begin
      for (int i = 0; i < 9; i++) begin
        c[i] = int'($urandom_range(0, 2 * IN_MAX + 1)) + IN_MIN;
      end
    end else begin
      for (int i = 0; i < 9; i++) begin
        c[i] = edge_value();
      end
    end
    for (int i = 0; i < 9; i++) begin
      m[i] = fit(c[i]);
    end
    return m;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // drop start for a while, called right after a rising edge
  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // present one word and hold it until it is taken
  task automatic send_matrix(matrix_t m);
    start   <= 1'b1;
    in_x0_i <= m[0];
    in_x1_i <= m[1];
    in_x2_i <= m[2];
    in_y0_i <= m[3];
    in_y1_i <= m[4];
    in_y2_i <= m[5];
    in_z0_i <= m[6];
    in_z1_i <= m[7];
    in_z2_i <= m[8];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    bit burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words: identity, mirroring, zero orientation and range ends
    send_matrix(rows(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(rows(ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    idle_for(1);
    send_matrix(rows(ONE, 0, 0, 0, ONE, 0, 0, 0, 0));
    send_matrix(rows(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(rows(IN_MAX, IN_MAX, IN_MAX, IN_MAX, IN_MAX, IN_MAX, IN_MAX, IN_MAX,
                     IN_MAX));
    idle_for(2);
    send_matrix(rows(IN_MIN, IN_MIN, IN_MIN, IN_MIN, IN_MIN, IN_MIN, IN_MIN, IN_MIN,
                     IN_MIN));
    send_matrix(rows(IN_MAX, IN_MIN, IN_MAX, IN_MIN, IN_MAX, IN_MIN, IN_MAX, IN_MAX,
                     IN_MAX));
    send_matrix(rows(IN_MAX, IN_MAX, IN_MIN, IN_MIN, IN_MAX, IN_MAX, 1, 1, 1));
    send_matrix(rows(ONE, 0, 0, ONE, 0, 0, 0, 0, ONE));
    idle_for(1);
    send_matrix(rows(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_matrix(rows(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
    send_matrix(rows(ONE, 3000, 0, 3000, ONE, 0, 0, 0, ONE));
    send_matrix(rows(98304, 0, 0, 0, 98304, 0, 0, 0, ONE));
    send_matrix(rows(1, -1, 1, -1, 1, -1, -1, -1, -1));
    idle_for(3);
    send_matrix(rows(87381, -87382, 87381, -87382, 87381, -87382, 87381, -87382, 87381));
    send_matrix(rows(-87382, 87381, -87382, 87381, -87382, 87381, -87382, 87381, -87382));
    send_matrix(rows(46341, 46341, 0, -46341, 46341, 0, 0, 0, -ONE));
    send_matrix(rows(IN_MAX, 0, 0, 0, IN_MIN, 0, 0, 0, IN_MAX));

    // random words in bursts and in gappy stretches
    burst = 1'b0;
    for (int n = 0; n < 900; n++) begin
      if (n % 60 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      idle_for(pick_gap(burst));
      send_matrix(random_rows());
    end
    start <= 1'b0;

    // drain the pipe, then make sure nothing extra comes out
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    sb.report_leftovers();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rmro_pkg.sv
rtl/rmro_ortho.sv
rtl/rmro_prod.sv
rtl/rmro_scale.sv
rtl/rmro_orient.sv
rtl/rotation_matrix_reorthogonalize_top.sv
rtl/rmro_checker.sv
tb/tb.sv
